[sv/fpcm_pkg.sv]
// Package: shared types and constants for the float to PCM sample converter.
`timescale 1ns / 1ps
package fpcm_pkg;

  typedef enum logic [2:0] {
    FMT_UNKNOWN,
    FMT_F32,
    FMT_I16,
    FMT_I24,
    FMT_I32
  } fmt_t;

  localparam logic [2:0] CFG_FORMAT_TAG     = 3'd0;
  localparam logic [2:0] CFG_SUB_FORMAT     = 3'd1;
  localparam logic [2:0] CFG_EXTENSION_SIZE = 3'd2;
  localparam logic [2:0] CFG_CHANNEL_COUNT  = 3'd3;
  localparam logic [2:0] CFG_SAMPLE_BITS    = 3'd4;
  localparam logic [2:0] CFG_FRAME_BYTES    = 3'd5;
  localparam logic [2:0] CFG_RATE_HZ        = 3'd6;

  localparam logic [1:0] TAG_PCM   = 2'd0;
  localparam logic [1:0] TAG_FLOAT = 2'd1;
  localparam logic [1:0] TAG_EXT   = 2'd2;

  localparam logic [1:0] SUB_PCM   = 2'd0;
  localparam logic [1:0] SUB_FLOAT = 2'd1;

  localparam logic [15:0] EXT_MIN_SIZE = 16'd22;

  localparam logic [30:0] SCALE_I16 = 31'd32767;
  localparam logic [30:0] SCALE_I24 = 31'd8388607;
  localparam logic [30:0] SCALE_I32 = 31'h7FFF_FFFF;

endpackage

[sv/float_to_pcm_sample_convert.sv]
// Top level: float32 audio sample to PCM word converter with format registers.
`timescale 1ns / 1ps
// channel  signals                                   direction
// input    in_valid, in_stall, float_bits, last_in   in (stall out)
// output   out_valid, out_stall, pcm_word, ...       out (stall in)
// config   cfg_we, cfg_index, cfg_data               in
// One sample per cycle while the output is not stalled. A transfer passes
// an input register, then the conversion into the result register.
// While a result waits on stall, an empty input register still takes a
// sample; with both registers full the input stalls.
// Format class is registered from the config registers after a config write.
// Reset is synchronous, clears the valids and loads format register defaults.
module float_to_pcm_sample_convert (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] float_bits,
  input  logic        last_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] pcm_word,
  output logic [2:0]  byte_count,
  output logic        format_known,
  output logic        last_out,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import fpcm_pkg::*;

  logic [1:0]  format_tag;
  logic [1:0]  sub_format;
  logic [15:0] extension_size;
  logic [15:0] channel_count;
  logic [15:0] sample_bits;
  logic [15:0] frame_bytes;
  logic [31:0] rate_hz;
  fmt_t        fmt;
  fmt_t        fmt_next;
  logic [1:0]  tag;
  logic [31:0] frame_calc;

  logic        v1;
  logic [31:0] bits1;
  logic        last1;
  logic        adv;
  logic [31:0] conv_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      format_tag     <= TAG_PCM;
      sub_format     <= 2'd2;
      extension_size <= 16'd0;
      channel_count  <= 16'd2;
      sample_bits    <= 16'd16;
      frame_bytes    <= 16'd4;
      rate_hz        <= 32'd48000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FORMAT_TAG:     format_tag     <= cfg_data[1:0];
        CFG_SUB_FORMAT:     sub_format     <= cfg_data[1:0];
        CFG_EXTENSION_SIZE: extension_size <= cfg_data[15:0];
        CFG_CHANNEL_COUNT:  channel_count  <= cfg_data[15:0];
        CFG_SAMPLE_BITS:    sample_bits    <= cfg_data[15:0];
        CFG_FRAME_BYTES:    frame_bytes    <= cfg_data[15:0];
        CFG_RATE_HZ:        rate_hz        <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    frame_calc = 32'(channel_count) * 32'(sample_bits[15:3]);
    tag        = format_tag;
    fmt_next   = FMT_UNKNOWN;
    if (channel_count != 16'd0 && rate_hz != 32'd0 && sample_bits != 16'd0 &&
        sample_bits[2:0] == 3'd0 && 32'(frame_bytes) == frame_calc &&
        !(format_tag == TAG_EXT && extension_size < EXT_MIN_SIZE)) begin
      if (format_tag == TAG_EXT) begin
        if (sub_format == SUB_FLOAT) begin
          tag = TAG_FLOAT;
        end else if (sub_format == SUB_PCM) begin
          tag = TAG_PCM;
        end
      end
      if (tag == TAG_FLOAT && sample_bits == 16'd32) begin
        fmt_next = FMT_F32;
      end else if (tag == TAG_PCM) begin
        if (sample_bits == 16'd16) begin
          fmt_next = FMT_I16;
        end else if (sample_bits == 16'd24) begin
          fmt_next = FMT_I24;
        end else if (sample_bits == 16'd32) begin
          fmt_next = FMT_I32;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt <= FMT_I16;
    end else begin
      fmt <= fmt_next;
    end
  end

  assign adv      = !(out_valid && out_stall);
  assign in_stall = v1 && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (!in_stall) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      bits1 <= float_bits;
      last1 <= last_in;
    end
  end

  fpcm_int_conv u_conv (
    .float_bits (bits1),
    .fmt        (fmt),
    .pcm_word   (conv_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v1) begin
      pcm_word     <= conv_word;
      format_known <= (fmt != FMT_UNKNOWN);
      last_out     <= last1;
      case (fmt)
        FMT_F32: byte_count <= 3'd4;
        FMT_I16: byte_count <= 3'd2;
        FMT_I24: byte_count <= 3'd3;
        FMT_I32: byte_count <= 3'd4;
        default: byte_count <= 3'd0;
      endcase
    end
  end

endmodule

[sv/fpcm_int_conv.sv]
// Float sample to integer PCM conversion: clamp, scale, double rounding as in software.
`timescale 1ns / 1ps
module fpcm_int_conv (
  input  logic [31:0]        float_bits,
  input  fpcm_pkg::fmt_t     fmt,
  output logic [31:0]        pcm_word
);
  import fpcm_pkg::*;

  logic          sign;
  logic [7:0]    ex;
  logic [22:0]   frac;
  logic [23:0]   mant;
  logic [30:0]   scale;
  logic [54:0]   prod;
  logic [5:0]    drop;
  logic          hi;
  logic [54:0]   keep;
  logic [54:0]   rem;
  logic [54:0]   half;
  logic          up1;
  logic [55:0]   rnd;
  logic [7:0]    shamt;
  logic [119:0]  big;
  logic [55:0]   ip;
  logic [63:0]   fr;
  logic          up2;
  logic [31:0]   mag;
  logic [31:0]   word;

  always_comb begin
    sign  = float_bits[31];
    ex    = float_bits[30:23];
    frac  = float_bits[22:0];
    mant  = {1'b1, frac};
    case (fmt)
      FMT_I16: scale = SCALE_I16;
      FMT_I24: scale = SCALE_I24;
      default: scale = SCALE_I32;
    endcase
    prod = 55'(mant) * 55'(scale);
    // round product to 24 (single) or 53 (double) significant bits
    case (fmt)
      FMT_I16: begin
        hi   = prod[38];
        drop = hi ? 6'd15 : 6'd14;
      end
      FMT_I24: begin
        hi   = prod[46];
        drop = hi ? 6'd23 : 6'd22;
      end
      default: begin
        hi   = prod[54];
        drop = hi ? 6'd2 : 6'd1;
      end
    endcase
    keep = prod >> drop;
    rem  = prod & ((55'd1 << drop) - 55'd1);
    half = 55'd1 << (drop - 6'd1);
    up1  = (rem > half) || ((rem == half) && keep[0]);
    rnd  = (56'(keep) + 56'(up1)) << drop;
    // round to integer
    shamt = 8'd150 - ex;
    big   = {rnd, 64'd0} >> shamt[5:0];
    ip    = big[119:64];
    fr    = big[63:0];
    if (fmt == FMT_I32) begin
      up2 = fr[63];
    end else begin
      up2 = fr[63] && ((fr[62:0] != 63'd0) || ip[0]);
    end
    if (ex >= 8'd127) begin
      mag = {1'b0, scale};
    end else if (ex == 8'd0 || shamt > 8'd63) begin
      mag = 32'd0;
    end else begin
      mag = ip[31:0] + 32'(up2);
    end
    if (ex == 8'hFF && frac != 23'd0) begin
      word = 32'd0;
    end else begin
      word = sign ? (32'd0 - mag) : mag;
    end
    case (fmt)
      FMT_F32: pcm_word = float_bits;
      FMT_I16: pcm_word = {16'd0, word[15:0]};
      FMT_I24: pcm_word = {8'd0, word[23:0]};
      FMT_I32: pcm_word = word;
      default: pcm_word = 32'd0;
    endcase
  end

endmodule
